[rtl/pqet_pkg.sv]
// Package for the power quality event timer: request, response and
// tracker control types, register indexes, reset values, magnitude helper.
// No dependencies.
package pqet_pkg;

   localparam int TIME_WIDTH      = 32;
   localparam int SAMPLE_WIDTH    = 24;
   localparam int PERIOD_WIDTH    = 32;
   localparam int SPAN_WIDTH      = 32;
   localparam int LIMIT_WIDTH     = 23;
   localparam int CSR_INDEX_WIDTH = 4;
   localparam int CSR_DATA_WIDTH  = 32;
   localparam int HITS_WIDTH      = 2;

   // Voltage needs this many exceeding samples before it alarms
   localparam logic [HITS_WIDTH-1:0] VOLTAGE_HITS_NEEDED = 2'd2;

   // Register indexes on the configuration port
   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_VOLTAGE_LIMIT      = 4'd0,
      CSR_CURRENT_LIMIT      = 4'd1,
      CSR_SHORT_PERIOD_LIMIT = 4'd2,
      CSR_LONG_PERIOD_LIMIT  = 4'd3
   } csr_index_type;

   // Reset values: full scale for the limits, 50.5 Hz and 49.5 Hz as periods
   localparam logic [LIMIT_WIDTH-1:0]  VOLTAGE_LIMIT_RESET      = 23'd8388607;
   localparam logic [LIMIT_WIDTH-1:0]  CURRENT_LIMIT_RESET      = 23'd8388607;
   localparam logic [PERIOD_WIDTH-1:0] SHORT_PERIOD_LIMIT_RESET = 32'd19802;
   localparam logic [PERIOD_WIDTH-1:0] LONG_PERIOD_LIMIT_RESET  = 32'd20202;

   typedef struct packed {
      logic signed [SAMPLE_WIDTH-1:0] voltage_mv;
      logic signed [SAMPLE_WIDTH-1:0] current_ma;
      logic [TIME_WIDTH-1:0]          time_us;
      logic [PERIOD_WIDTH-1:0]        period_us;
      logic                           period_present;
      logic                           last_sample;
   } pqet_req_type;

   typedef struct packed {
      logic                  overvoltage_flag;
      logic [SPAN_WIDTH-1:0] overvoltage_span;
      logic                  overcurrent_flag;
      logic [SPAN_WIDTH-1:0] overcurrent_span;
      logic                  high_freq_flag;
      logic [SPAN_WIDTH-1:0] high_freq_span;
      logic                  low_freq_flag;
      logic [SPAN_WIDTH-1:0] low_freq_span;
   } pqet_rsp_type;

   // Per-condition tracker control
   typedef struct packed {
      logic step;   // a sample is consumed this cycle
      logic hit;    // the condition holds on this sample
      logic fresh;  // no earlier hit in this record
   } pqet_track_ctrl_type;

   // Unsigned magnitude; the most negative code maps to 2^(SAMPLE_WIDTH-1)
   function automatic logic [SAMPLE_WIDTH-1:0] sample_mag(
      input logic [SAMPLE_WIDTH-1:0] raw);
      logic [SAMPLE_WIDTH-1:0] neg;
      neg = ~raw + {{(SAMPLE_WIDTH-1){1'b0}}, 1'b1};
      return raw[SAMPLE_WIDTH-1] ? neg : raw;
   endfunction

endpackage

[rtl/pqet_track.sv]
// First/last timestamp tracker for one alarm condition.
// Depends on pqet_pkg.
module pqet_track
   import pqet_pkg::*;
(
   input  logic                    clock,
   input  pqet_track_ctrl_type     ctrl,
   input  logic [TIME_WIDTH-1:0]   time_us,
   output logic [SPAN_WIDTH-1:0]   span
);

   logic [TIME_WIDTH-1:0] first_ff, first_in;
   logic [TIME_WIDTH-1:0] last_ff, last_in;
   logic [TIME_WIDTH-1:0] diff;

   // First time latches on the opening hit, last time follows every hit
   always_comb begin
      first_in = (ctrl.hit && ctrl.fresh) ? time_us : first_ff;
      last_in  = ctrl.hit ? time_us : last_ff;
      diff     = last_in - first_in;
      span     = diff[SPAN_WIDTH-1:0];
   end

   // Stale values are never reported: a flag always implies a fresh first hit
   always_ff @(posedge clock) begin
      if (ctrl.step) begin
         first_ff <= first_in;
         last_ff  <= last_in;
      end
   end

endmodule

[rtl/power_quality_event_timer_unit.sv]
// Power quality event timer: checks each meter sample for over/under limits
// and reports alarm flags and durations on the last sample of a record.
// A last request passes the input stage and then the result register.
// Throughput: one request per cycle; a last request waits only while the
// result register holds a response that is not being taken.
// Reset (synchronous, active high) clears the pipeline, the record state
// and loads the limit registers with their defaults.
module power_quality_event_timer_unit
   import pqet_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  pqet_req_type                req_data,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output pqet_rsp_type                rsp_data,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]   csr_wdata
);

   // Limit registers
   logic [LIMIT_WIDTH-1:0]  voltage_limit_ff, current_limit_ff;
   logic [PERIOD_WIDTH-1:0] short_period_limit_ff, long_period_limit_ff;

   // Input stage
   logic         s1_valid_ff, s1_valid_in;
   pqet_req_type s1_ff;

   // Record state
   logic [HITS_WIDTH-1:0] voltage_hits_ff, voltage_hits_in, voltage_hits_next;
   logic [2:0]            seen_ff, seen_in, seen_next;

   // Result register
   logic         rsp_valid_ff, rsp_valid_in;
   pqet_rsp_type rsp_ff, rsp_in;

   logic out_free, s1_go, report;
   logic v_hit, c_hit, hf_hit, lf_hit, period_ok;
   logic [SPAN_WIDTH-1:0] v_span, c_span, hf_span, lf_span;
   pqet_track_ctrl_type   v_ctrl, c_ctrl, hf_ctrl, lf_ctrl;

   assign csr_ready = 1'b1;

   // Configuration writes; unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         voltage_limit_ff      <= VOLTAGE_LIMIT_RESET;
         current_limit_ff      <= CURRENT_LIMIT_RESET;
         short_period_limit_ff <= SHORT_PERIOD_LIMIT_RESET;
         long_period_limit_ff  <= LONG_PERIOD_LIMIT_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_VOLTAGE_LIMIT:      voltage_limit_ff      <= csr_wdata[LIMIT_WIDTH-1:0];
            CSR_CURRENT_LIMIT:      current_limit_ff      <= csr_wdata[LIMIT_WIDTH-1:0];
            CSR_SHORT_PERIOD_LIMIT: short_period_limit_ff <= csr_wdata[PERIOD_WIDTH-1:0];
            CSR_LONG_PERIOD_LIMIT:  long_period_limit_ff  <= csr_wdata[PERIOD_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   // Flow control: only a last sample needs room in the result register
   always_comb begin
      out_free    = !rsp_valid_ff || rsp_ready;
      s1_go       = s1_valid_ff && (!s1_ff.last_sample || out_free);
      report      = s1_go && s1_ff.last_sample;
      req_ready   = !s1_valid_ff || s1_go;
      s1_valid_in = req_ready ? req_valid : s1_valid_ff;
   end

   // Condition checks on the staged sample
   always_comb begin
      v_hit     = sample_mag(s1_ff.voltage_mv) > {1'b0, voltage_limit_ff};
      c_hit     = sample_mag(s1_ff.current_ma) > {1'b0, current_limit_ff};
      period_ok = s1_ff.period_present && (s1_ff.period_us != '0);
      hf_hit    = period_ok && (s1_ff.period_us < short_period_limit_ff);
      lf_hit    = period_ok && (s1_ff.period_us > long_period_limit_ff);
   end

   // Voltage hit counter and seen bits, cleared after a report
   always_comb begin
      voltage_hits_next = voltage_hits_ff;
      if (v_hit && (voltage_hits_ff < VOLTAGE_HITS_NEEDED))
         voltage_hits_next = voltage_hits_ff + 2'd1;
      seen_next = seen_ff | {lf_hit, hf_hit, c_hit};

      voltage_hits_in = voltage_hits_ff;
      seen_in         = seen_ff;
      if (s1_go) begin
         voltage_hits_in = s1_ff.last_sample ? '0 : voltage_hits_next;
         seen_in         = s1_ff.last_sample ? '0 : seen_next;
      end
   end

   always_comb begin
      v_ctrl  = '{step: s1_go, hit: v_hit,  fresh: (voltage_hits_ff == '0)};
      c_ctrl  = '{step: s1_go, hit: c_hit,  fresh: !seen_ff[0]};
      hf_ctrl = '{step: s1_go, hit: hf_hit, fresh: !seen_ff[1]};
      lf_ctrl = '{step: s1_go, hit: lf_hit, fresh: !seen_ff[2]};
   end

   pqet_track u_track_v  (.clock(clock), .ctrl(v_ctrl),  .time_us(s1_ff.time_us),
                          .span(v_span));
   pqet_track u_track_c  (.clock(clock), .ctrl(c_ctrl),  .time_us(s1_ff.time_us),
                          .span(c_span));
   pqet_track u_track_hf (.clock(clock), .ctrl(hf_ctrl), .time_us(s1_ff.time_us),
                          .span(hf_span));
   pqet_track u_track_lf (.clock(clock), .ctrl(lf_ctrl), .time_us(s1_ff.time_us),
                          .span(lf_span));

   // Report assembly: span is zero whenever its flag is clear
   always_comb begin
      rsp_in.overvoltage_flag = (voltage_hits_next >= VOLTAGE_HITS_NEEDED);
      rsp_in.overcurrent_flag = seen_next[0];
      rsp_in.high_freq_flag   = seen_next[1];
      rsp_in.low_freq_flag    = seen_next[2];
      rsp_in.overvoltage_span = rsp_in.overvoltage_flag ? v_span  : '0;
      rsp_in.overcurrent_span = rsp_in.overcurrent_flag ? c_span  : '0;
      rsp_in.high_freq_span   = rsp_in.high_freq_flag   ? hf_span : '0;
      rsp_in.low_freq_span    = rsp_in.low_freq_flag    ? lf_span : '0;
      rsp_valid_in = report ? 1'b1 : (rsp_valid_ff && !rsp_ready);
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         voltage_hits_ff <= '0;
         seen_ff         <= '0;
      end else begin
         s1_valid_ff     <= s1_valid_in;
         rsp_valid_ff    <= rsp_valid_in;
         voltage_hits_ff <= voltage_hits_in;
         seen_ff         <= seen_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_ready && req_valid)
         s1_ff <= req_data;
      if (report)
         rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

[rtl/pqet_checker.sv]
// Port-level checks for the power quality event timer, bound to the top.
// Depends on pqet_pkg and power_quality_event_timer_unit.
module pqet_checker
   import pqet_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         req_ready,
   input logic         rsp_valid,
   input logic         rsp_ready,
   input pqet_rsp_type rsp_data
);

   // Reset empties the result register
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // A stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");

   // Requests are only held off while a response is pending
   a_no_idle_stall: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request stalled with empty result register");

   // A clear flag reports a zero span
   a_span_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
         (rsp_data.overvoltage_flag || rsp_data.overvoltage_span == '0) &&
         (rsp_data.overcurrent_flag || rsp_data.overcurrent_span == '0) &&
         (rsp_data.high_freq_flag   || rsp_data.high_freq_span   == '0) &&
         (rsp_data.low_freq_flag    || rsp_data.low_freq_span    == '0))
      else $error("nonzero span with flag clear");

endmodule

bind power_quality_event_timer_unit pqet_checker u_pqet_checker (.*);

[tb/sv/testbench.sv]
// Self-checking testbench for power_quality_event_timer_unit: a directed request
// table and constrained-free random records, checked against an in-bench predictor.
// Depends on pqet_pkg and the unit's RTL only.
module testbench;
   import pqet_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int HOLD_CYCLES    = 40;
   localparam int PHASE_ITEMS    = 150;
   localparam int LAST_ODDS      = 8;
   localparam int DRAIN_CYCLES   = 4;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_UNUSED_INDEX = 4'hF;
   localparam logic [SAMPLE_WIDTH-1:0]    SAMPLE_MIN       = 24'h800000;
   localparam logic [SAMPLE_WIDTH-1:0]    SAMPLE_MAX       = 24'h7FFFFF;

   logic                       clock     = 1'b0;
   logic                       reset     = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   pqet_req_type               req_data  = '0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   pqet_rsp_type               rsp_data;
   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [CSR_DATA_WIDTH-1:0]  csr_wdata = '0;

   always #1 clock = ~clock;

   power_quality_event_timer_unit DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Predictor state: limits and the open record
   logic [LIMIT_WIDTH-1:0]  model_voltage_limit = VOLTAGE_LIMIT_RESET;
   logic [LIMIT_WIDTH-1:0]  model_current_limit = CURRENT_LIMIT_RESET;
   logic [PERIOD_WIDTH-1:0] model_short_limit   = SHORT_PERIOD_LIMIT_RESET;
   logic [PERIOD_WIDTH-1:0] model_long_limit    = LONG_PERIOD_LIMIT_RESET;
   logic [HITS_WIDTH-1:0]   volt_hits           = '0;
   logic [2:0]              seen_bits           = '0;
   logic [TIME_WIDTH-1:0]   first_hit [4]       = '{default: '0};
   logic [TIME_WIDTH-1:0]   last_hit  [4]       = '{default: '0};

   pqet_rsp_type pending_reports[$];

   typedef struct {
      pqet_req_type s;
      bit           typed;
      pqet_rsp_type r;
   } stim_row_type;
   stim_row_type stim_rows[$];

   logic [TIME_WIDTH-1:0] time_cursor = '0;
   bit hold_rsp = 1'b0;
   bit calm     = 1'b0;
   int mismatches      = 0;
   int samples_sent    = 0;
   int reports_checked = 0;
   int settings_used   = 1;
   int idle_cycles     = 0;

   function void clear_record();
      volt_hits = '0;
      seen_bits = '0;
      for (int k = 0; k < 4; k++) begin
         first_hit[k] = '0;
         last_hit[k]  = '0;
      end
   endfunction

   // Absolute value one bit wider, so the most negative code stays exact
   function automatic logic [SAMPLE_WIDTH:0] magnitude(logic [SAMPLE_WIDTH-1:0] raw);
      if (raw[SAMPLE_WIDTH-1])
         return {1'b1, {SAMPLE_WIDTH{1'b0}}} - {1'b0, raw};
      return {1'b0, raw};
   endfunction

   function void note_hit(int k, logic [TIME_WIDTH-1:0] t, bit fresh);
      if (fresh)
         first_hit[k] = t;
      last_hit[k] = t;
   endfunction

   // Fold one sample into the record; returns 1 with the report on a last sample
   function automatic bit track_sample(input pqet_req_type s, output pqet_rsp_type r);
      logic                  period_ok;
      logic                  flag [4];
      logic [SPAN_WIDTH-1:0] span [4];
      period_ok = s.period_present && (s.period_us != '0);
      r = '0;
      if (magnitude(s.voltage_mv) > {2'b00, model_voltage_limit}) begin
         note_hit(0, s.time_us, volt_hits == '0);
         if (volt_hits < VOLTAGE_HITS_NEEDED)
            volt_hits++;
      end
      if (magnitude(s.current_ma) > {2'b00, model_current_limit}) begin
         note_hit(1, s.time_us, !seen_bits[0]);
         seen_bits[0] = 1'b1;
      end
      if (period_ok && s.period_us < model_short_limit) begin
         note_hit(2, s.time_us, !seen_bits[1]);
         seen_bits[1] = 1'b1;
      end
      if (period_ok && s.period_us > model_long_limit) begin
         note_hit(3, s.time_us, !seen_bits[2]);
         seen_bits[2] = 1'b1;
      end
      if (!s.last_sample)
         return 1'b0;
      flag[0] = (volt_hits >= VOLTAGE_HITS_NEEDED);
      flag[1] = seen_bits[0];
      flag[2] = seen_bits[1];
      flag[3] = seen_bits[2];
      for (int k = 0; k < 4; k++)
         span[k] = flag[k] ? SPAN_WIDTH'(last_hit[k] - first_hit[k]) : '0;
      r.overvoltage_flag = flag[0];
      r.overvoltage_span = span[0];
      r.overcurrent_flag = flag[1];
      r.overcurrent_span = span[1];
      r.high_freq_flag   = flag[2];
      r.high_freq_span   = span[2];
      r.low_freq_flag    = flag[3];
      r.low_freq_span    = span[3];
      clear_record();
      return 1'b1;
   endfunction

   function automatic pqet_req_type meter_sample(logic [SAMPLE_WIDTH-1:0] v, c,
                                                 logic [31:0] t, p, bit present, last);
      pqet_req_type s;
      s.voltage_mv     = v;
      s.current_ma     = c;
      s.time_us        = t;
      s.period_us      = p;
      s.period_present = present;
      s.last_sample    = last;
      return s;
   endfunction

   function automatic pqet_rsp_type alarm_report(bit ovf, logic [31:0] ovs, bit ocf,
                                                 logic [31:0] ocs, bit hff, logic [31:0] hfs,
                                                 bit lff, logic [31:0] lfs);
      pqet_rsp_type r;
      r.overvoltage_flag = ovf;
      r.overvoltage_span = ovs;
      r.overcurrent_flag = ocf;
      r.overcurrent_span = ocs;
      r.high_freq_flag   = hff;
      r.high_freq_span   = hfs;
      r.low_freq_flag    = lff;
      r.low_freq_span    = lfs;
      return r;
   endfunction

   function void add_row(pqet_req_type s, bit typed, pqet_rsp_type r);
      stim_row_type row;
      row.s     = s;
      row.typed = typed;
      row.r     = r;
      stim_rows.insert(stim_rows.size(), row);
   endfunction

   // Random levels cluster around the limit so both sides of the compare show up
   function automatic logic [SAMPLE_WIDTH-1:0] pick_level(logic [LIMIT_WIDTH-1:0] lim);
      logic [SAMPLE_WIDTH:0]   m;
      logic [SAMPLE_WIDTH-1:0] v;
      case ($urandom_range(0, 5))
         0: v = SAMPLE_WIDTH'($urandom);
         1, 2: begin
            m = (SAMPLE_WIDTH+1)'({2'b00, lim} + $urandom_range(0, 2) - 1);
            v = m[SAMPLE_WIDTH-1:0];
            if ($urandom_range(0, 1))
               v = -v;
         end
         3: v = $urandom_range(0, 1) ? SAMPLE_MIN : SAMPLE_MAX;
         default: begin
            v = SAMPLE_WIDTH'($urandom_range(0, 255));
            if ($urandom_range(0, 1))
               v = -v;
         end
      endcase
      return v;
   endfunction

   function automatic logic [PERIOD_WIDTH-1:0] pick_period();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return model_short_limit + $urandom_range(0, 2) - 1;
         2: return model_long_limit + $urandom_range(0, 2) - 1;
         3: return $urandom;
         default: return $urandom_range(19000, 21000);
      endcase
   endfunction

   // Timestamps mostly climb; now and then they jump anywhere, backwards included
   function automatic pqet_req_type random_sample();
      pqet_req_type s;
      if ($urandom_range(0, 9) == 0)
         time_cursor = $urandom;
      else
         time_cursor += $urandom_range(0, 30000);
      s.voltage_mv     = pick_level(model_voltage_limit);
      s.current_ma     = pick_level(model_current_limit);
      s.time_us        = time_cursor;
      s.period_us      = pick_period();
      s.period_present = ($urandom_range(0, 3) != 0);
      s.last_sample    = ($urandom_range(1, LAST_ODDS) == 1);
      return s;
   endfunction

   // Offer one request, optionally after an idle burst, and predict on acceptance
   task automatic send_sample(input pqet_req_type s, input bit typed,
                              input pqet_rsp_type typed_rsp, input bit may_idle);
      pqet_rsp_type predicted;
      if (may_idle && !calm && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= s;
      do @(posedge clock); while (!req_ready);
      samples_sent++;
      if (track_sample(s, predicted))
         pending_reports.insert(pending_reports.size(), typed ? typed_rsp : predicted);
   endtask

   task automatic run_random(int count, bit may_idle);
      repeat (count) send_sample(random_sample(), 1'b0, '0, may_idle);
   endtask

   // Stop offering, then wait out pending reports and the pipeline
   task automatic settle();
      req_valid <= 1'b0;
      while (pending_reports.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(logic [CSR_INDEX_WIDTH-1:0] idx, logic [31:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_VOLTAGE_LIMIT:      model_voltage_limit = data[LIMIT_WIDTH-1:0];
         CSR_CURRENT_LIMIT:      model_current_limit = data[LIMIT_WIDTH-1:0];
         CSR_SHORT_PERIOD_LIMIT: model_short_limit   = data;
         CSR_LONG_PERIOD_LIMIT:  model_long_limit    = data;
         default: ;
      endcase
   endtask

   // Full limit set plus a write to an unmapped index that must change nothing
   task automatic program_limits(logic [31:0] v, c, s, l);
      write_register(CSR_VOLTAGE_LIMIT, v);
      write_register(CSR_CURRENT_LIMIT, c);
      write_register(CSR_SHORT_PERIOD_LIMIT, s);
      write_register(CSR_LONG_PERIOD_LIMIT, l);
      write_register(CSR_UNUSED_INDEX, $urandom);
      csr_valid <= 1'b0;
      settings_used++;
   endtask

   function void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, actual %0h", name, want, got);
         mismatches++;
      end
   endfunction

   // Report checker
   always @(posedge clock) begin
      pqet_rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_reports.size() == 0) begin
            $error("report arrived with none pending");
            mismatches++;
         end else begin
            want = pending_reports.pop_front();
            check_field("overvoltage_flag", want.overvoltage_flag, rsp_data.overvoltage_flag);
            check_field("overvoltage_span", want.overvoltage_span, rsp_data.overvoltage_span);
            check_field("overcurrent_flag", want.overcurrent_flag, rsp_data.overcurrent_flag);
            check_field("overcurrent_span", want.overcurrent_span, rsp_data.overcurrent_span);
            check_field("high_freq_flag", want.high_freq_flag, rsp_data.high_freq_flag);
            check_field("high_freq_span", want.high_freq_span, rsp_data.high_freq_span);
            check_field("low_freq_flag", want.low_freq_flag, rsp_data.low_freq_flag);
            check_field("low_freq_span", want.low_freq_span, rsp_data.low_freq_span);
            reports_checked++;
         end
      end
   end

   // Receiver: random back-pressure bursts, one long hold on request
   initial begin
      forever begin
         @(posedge clock);
         if (hold_rsp) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_rsp = 1'b0;
            rsp_ready <= 1'b1;
         end else if (!calm && $urandom_range(0, 4) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clock);
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Watchdog: any handshake counts as progress
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
   end

   initial begin
      wait (idle_cycles >= WATCHDOG_LIMIT);
      $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
      $display("CHECKS FAILED");
      $finish;
   end

   // Main sequence
   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed rows at reset limits
      add_row(meter_sample('0, '0, 100, 0, 0, 1), 1, alarm_report(0, 0, 0, 0, 0, 0, 0, 0));
      add_row(meter_sample(SAMPLE_MIN, '0, 10, 0, 0, 0), 0, '0);
      add_row(meter_sample(SAMPLE_MIN, SAMPLE_MIN, 30, 19801, 1, 0), 0, '0);
      add_row(meter_sample(SAMPLE_MAX, SAMPLE_MAX, 45, 20203, 1, 1), 1,
              alarm_report(1, 20, 1, 0, 1, 0, 1, 0));
      // lone overvoltage sample does not alarm
      add_row(meter_sample(SAMPLE_MIN, '0, 5, 0, 0, 1), 1, alarm_report(0, 0, 0, 0, 0, 0, 0, 0));
      // zero period, and a period without its present bit
      add_row(meter_sample('0, '0, 1, 0, 1, 0), 0, '0);
      add_row(meter_sample('0, '0, 2, 1, 0, 1), 1, alarm_report(0, 0, 0, 0, 0, 0, 0, 0));
      // timestamp wraps inside the record
      add_row(meter_sample('0, SAMPLE_MIN, 32'hFFFF_FFF0, 1, 1, 0), 0, '0);
      add_row(meter_sample('0, SAMPLE_MIN, 32'h10, 32'hFFFF_FFFF, 1, 1), 1,
              alarm_report(0, 0, 1, 32'h20, 1, 0, 1, 0));
      // periods right at the limits, voltage hit count saturates
      add_row(meter_sample(SAMPLE_MIN, '0, 100, 19802, 1, 0), 0, '0);
      add_row(meter_sample(SAMPLE_MIN, '0, 200, 20202, 1, 0), 0, '0);
      add_row(meter_sample(SAMPLE_MIN, '0, 300, 0, 0, 1), 1,
              alarm_report(1, 200, 0, 0, 0, 0, 0, 0));
      add_row(meter_sample(SAMPLE_MAX, SAMPLE_MIN, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 0), 0, '0);
      add_row(meter_sample(24'hFFFFFF, 24'h000001, 0, 19801, 1, 1), 1,
              alarm_report(0, 0, 1, 0, 1, 0, 1, 0));
      add_row(meter_sample(24'h01E240, 24'hF6050F, 1000, 20000, 1, 0), 0, '0);
      add_row(meter_sample(24'hAAAAAA, 24'h555555, 32'hAAAA_AAAA, 32'h5555_5555, 1, 1), 0, '0);
      foreach (stim_rows[i])
         send_sample(stim_rows[i].s, stim_rows[i].typed, stim_rows[i].r, 1'b1);
      settle();

      // Zero magnitude limits (voltage written with junk above bit 22), no period alarms
      program_limits(32'hFF80_0000, 32'h0, 32'h0, 32'hFFFF_FFFF);
      run_random(PHASE_ITEMS, 1'b1);
      settle();

      // Full-scale limits, every valid period alarms; receiver holds off meanwhile
      program_limits(32'h007F_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0);
      hold_rsp = 1'b1;
      run_random(PHASE_ITEMS, 1'b0);
      settle();

      // Mid-range limits with the nominal frequency window
      program_limits(32'd1000000, 32'd250000, 32'd19802, 32'd20202);
      run_random(PHASE_ITEMS, 1'b1);
      settle();

      // Random limits, no idling on either side
      program_limits($urandom_range(0, 8388607), $urandom_range(0, 8388607),
                     $urandom_range(15000, 20000), $urandom_range(20000, 25000));
      calm = 1'b1;
      run_random(PHASE_ITEMS, 1'b1);
      settle();

      $display("Sent %0d meter samples; %0d alarm reports compared across %0d limit settings.",
               samples_sent, reports_checked, settings_used);
      if (mismatches == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
